>>> rtl/core/des_pkg.sv
// Shared types and sizing for the descending exchange sorter.
package des_pkg;

  // Number of cells in the sorting chain (values held per set).
  localparam int unsigned SetSize = 16;

  typedef logic signed [7:0] value_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic insert;  // place the incoming value at its sorted position
    logic shift;   // move every value one cell toward the head
  } cell_ctrl_t;

endpackage

>>> rtl/core/descending_exchange_sorter.sv
// Top level of the descending exchange sorter: cell chain and run control.
//
// Values enter one per cycle: a request is taken when start is high and busy
// is low, and the chain of SetSize cells places it at its sorted position in
// that same cycle. A request marked final_item_i starts the run: beginning in
// the next cycle, busy is high and the held values come out largest first,
// one per cycle on valid_o, until every held value (1..SetSize of them) is
// out; the chain shifts one cell toward the head each cycle. run_end_o marks
// the smallest value. Values beyond SetSize
// are dropped and overflowed_o is high on every result of that run. The
// receiver cannot stall; results are driven straight from the head cell.
module descending_exchange_sorter (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  des_pkg::value_t value_i,
  input  logic            final_item_i,
  output logic            valid_o,
  output des_pkg::value_t sorted_value_o,
  output logic            run_end_o,
  output logic            overflowed_o
);
  import des_pkg::*;

  value_t     cell_value [SetSize];
  logic       cell_valid [SetSize];
  logic       cell_push  [SetSize];
  cell_ctrl_t ctrl;

  logic emit_q, emit_d;
  logic ovf_q, ovf_d;
  logic accept, full;

  assign accept = start && !emit_q;
  assign full   = cell_valid[SetSize-1];

  assign ctrl.insert = accept && !full;
  assign ctrl.shift  = emit_q;

  for (genvar i = 0; i < SetSize; i++) begin : g_cell
    value_t left_value, right_value;
    logic   left_valid, left_push, right_valid;

    if (i == 0) begin : g_head
      assign left_value = '0;
      assign left_valid = 1'b0;
      assign left_push  = 1'b0;
    end else begin : g_mid
      assign left_value = cell_value[i-1];
      assign left_valid = cell_valid[i-1];
      assign left_push  = cell_push[i-1];
    end

    if (i == SetSize - 1) begin : g_tail
      assign right_value = '0;
      assign right_valid = 1'b0;
    end else begin : g_body
      assign right_value = cell_value[i+1];
      assign right_valid = cell_valid[i+1];
    end

    des_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .new_value_i  (value_i),
      .left_value_i (left_value),
      .left_valid_i (left_valid),
      .left_push_i  (left_push),
      .right_value_i(right_value),
      .right_valid_i(right_valid),
      .value_o      (cell_value[i]),
      .valid_o      (cell_valid[i]),
      .push_o       (cell_push[i])
    );
  end

  // Last result of the run: nothing left behind the head cell.
  assign run_end_o = emit_q && !cell_valid[1];

  always_comb begin
    emit_d = emit_q;
    ovf_d  = ovf_q;
    if (emit_q) begin
      if (run_end_o) begin
        emit_d = 1'b0;
        ovf_d  = 1'b0;
      end
    end else if (accept) begin
      if (full) ovf_d = 1'b1;
      if (final_item_i) emit_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_q <= 1'b0;
      ovf_q  <= 1'b0;
    end else begin
      emit_q <= emit_d;
      ovf_q  <= ovf_d;
    end
  end

  assign busy           = emit_q;
  assign valid_o        = emit_q;
  assign sorted_value_o = cell_value[0];
  assign overflowed_o   = ovf_q;

endmodule

>>> rtl/core/des_cell.sv
// One cell of the sorting chain: holds one value and its valid bit.
module des_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  des_pkg::cell_ctrl_t ctrl_i,
  input  des_pkg::value_t    new_value_i,
  input  des_pkg::value_t    left_value_i,
  input  logic               left_valid_i,
  input  logic               left_push_i,
  input  des_pkg::value_t    right_value_i,
  input  logic               right_valid_i,
  output des_pkg::value_t    value_o,
  output logic               valid_o,
  output logic               push_o
);
  import des_pkg::*;

  value_t value_q, value_d;
  logic   valid_q, valid_d;

  // Incoming value belongs at or before this cell.
  assign push_o = !valid_q || (new_value_i > value_q);

  always_comb begin
    value_d = value_q;
    valid_d = valid_q;
    if (ctrl_i.shift) begin
      value_d = right_value_i;
      valid_d = right_valid_i;
    end else if (ctrl_i.insert) begin
      if (left_push_i) begin
        value_d = left_value_i;
        valid_d = left_valid_i;
      end else if (push_o) begin
        value_d = new_value_i;
        valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign valid_o = valid_q;

endmodule

>>> rtl/core/des_checker.sv
// Port-level checks for the descending exchange sorter, bound to the top.
module des_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            start,
  input logic            busy,
  input logic            final_item_i,
  input logic            valid_o,
  input des_pkg::value_t sorted_value_o,
  input logic            run_end_o,
  input logic            overflowed_o
);
  import des_pkg::*;

  // A final request starts the run in the next cycle.
  a_run_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && final_item_i |=> valid_o)
    else $error("run did not start after final request");

  // A run is unbroken until its end marker.
  a_run_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !run_end_o |=> valid_o)
    else $error("run broke before run_end_o");

  // Results come out in non-increasing order.
  a_descending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !run_end_o |=> sorted_value_o <= $past(sorted_value_o))
    else $error("results not in descending order");

  // Overflow flag is constant across a run.
  a_ovf_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !run_end_o |=> $stable(overflowed_o))
    else $error("overflowed_o changed within a run");

  // Block is ready again right after the run ends.
  a_idle_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && run_end_o |=> !busy && !valid_o)
    else $error("block still busy after run_end_o");

endmodule

bind descending_exchange_sorter des_checker u_des_checker (.*);
